[hdl/sobel_pkg.sv]
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // Largest supported image side and line store geometry
    localparam int MAX_SIDE = 1024;
    localparam int ADDR_W   = $clog2(MAX_SIDE);
    localparam int CNT_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 11;
    localparam int MIN_SIDE = 3;

    // Pixel and result widths
    localparam int PIX_W    = 8;
    localparam int MAG_W    = 11;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 20;
    localparam int RAD_W    = 21;

    // Square root: two radicand bits per step
    localparam int ROOT_STEPS = (RAD_W + 1) / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // Window slots: left column 0..2, middle column 3..5 (top, middle, bottom)
    localparam int WIN_N = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } sobel_state_t;

    typedef struct packed {
        logic accept;
        logic mem_we;
        logic do_square;
        logic do_sum;
        logic do_root;
        logic load_out;
    } sobel_ctrl_t;

endpackage

[hdl/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel gradient magnitude over a streamed square image.
//
// Usage: pixels of a square image enter on the s_ channel in raster order,
// one request per pixel. The user writes the image side via cfg_wr_en/cfg_wr_data
// only while idle (the block does not enforce it); a write also restarts the frame at row 0, col 0.
// Sides below 3 act as 3, above 1024 act as 1024.
// Two line stores (synchronous RAMs, registered read) hold the two rows above
// the incoming pixel; a six-pixel register window holds the left and middle
// columns. Each interior pixel gives one request on the m_ channel carrying
// floor(sqrt(gx^2 + gy^2)); m_tlast marks the last result of the frame.
// Border pixels give no result.
// Steps: a border pixel is accepted, then its line store read is used. An
// interior pixel is read, then gradient, square, sum, the root iterations in
// the shared digit-by-digit unit, and handoff to the output register. Only
// then is a new pixel accepted; m_tvalid rises the cycle after the handoff.
// The output register lets the next pixel be accepted while a result waits;
// if m_tready stays low, the next result is held until the register frees.
// Reset (aresetn low, synchronous) clears position counters, window, state and the
// output valid; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [sobel_pkg::SIDE_W-1:0] cfg_wr_data,
    // pixel stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] pixel (signed)
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [10:0] magnitude, [15:11] zero
    output logic                      m_tlast    // last_of_frame
);
    import sobel_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sobel_state_t                state_reg, state_next;
    sobel_ctrl_t                 ctrl;

    logic [SIDE_W-1:0]           side_cfg_reg;
    logic [CNT_W-1:0]            col_reg, row_reg;
    logic [CNT_W-1:0]            cur_col_reg, cur_row_reg;
    logic [PIX_W-1:0]            pix_reg;
    logic [PIX_W-1:0]            win_reg [WIN_N];

    logic [PIX_W-1:0]            older_mem [MAX_SIDE];
    logic [PIX_W-1:0]            newer_mem [MAX_SIDE];
    logic [PIX_W-1:0]            older_rd_reg, newer_rd_reg;

    logic                        interior_reg;
    logic                        last_reg;
    logic signed [GRAD_W-1:0]    gx_reg, gy_reg;
    logic [SQ_W-1:0]             sqx_reg, sqy_reg;
    logic [RAD_W-1:0]            rem_reg, rem_next;
    logic [RAD_W:0]              root_reg, root_next;
    logic [RAD_W-1:0]            bit_reg;
    logic [STEP_W-1:0]           step_reg;

    logic                        m_tvalid_reg;
    logic [MAG_W-1:0]            mag_reg;
    logic                        m_tlast_reg;

    // ------------------------------------------------------------------
    // Effective side and position of the incoming pixel
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] side_eff;
    logic [CNT_W-1:0]  col_cur, row_cur;
    logic [SIDE_W-1:0] col_inc, row_inc;
    logic [CNT_W-1:0]  col_next, row_next;

    always_comb begin
        if (side_cfg_reg < SIDE_W'(MIN_SIDE)) begin
            side_eff = SIDE_W'(MIN_SIDE);
        end else if (side_cfg_reg > SIDE_W'(MAX_SIDE)) begin
            side_eff = SIDE_W'(MAX_SIDE);
        end else begin
            side_eff = side_cfg_reg;
        end
        col_cur = (SIDE_W'(col_reg) >= side_eff) ? '0 : col_reg;
        row_cur = (SIDE_W'(row_reg) >= side_eff) ? '0 : row_reg;
    end

    // Advance position after the current pixel
    always_comb begin
        col_inc  = SIDE_W'(cur_col_reg) + SIDE_W'(1);
        row_inc  = SIDE_W'(cur_row_reg) + SIDE_W'(1);
        col_next = cur_col_reg;
        row_next = cur_row_reg;
        if (col_inc >= side_eff) begin
            col_next = '0;
            row_next = (row_inc >= side_eff) ? '0 : row_inc[CNT_W-1:0];
        end else begin
            col_next = col_inc[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_FETCH;
            end
            ST_FETCH: begin
                state_next = interior_reg ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT: begin
                if (step_reg == STEP_W'(ROOT_STEPS - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // State machine: control outputs
    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:   ctrl.accept    = s_tvalid;
            ST_FETCH:  ctrl.mem_we    = 1'b1;
            ST_SQUARE: ctrl.do_square = 1'b1;
            ST_SUM:    ctrl.do_sum    = 1'b1;
            ST_ROOT:   ctrl.do_root   = 1'b1;
            ST_DONE:   ctrl.load_out  = out_free;
            default:   ctrl = '0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and position counters
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_cfg_reg <= SIDE_W'(MAX_SIDE);
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (cfg_wr_en) begin
            side_cfg_reg <= cfg_wr_data;
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (ctrl.mem_we) begin
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    // Capture the accepted request and its position
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            pix_reg      <= s_tdata;
            cur_col_reg  <= col_cur;
            cur_row_reg  <= row_cur;
            interior_reg <= (row_cur >= CNT_W'(2)) && (col_cur >= CNT_W'(2));
            last_reg     <= (SIDE_W'(row_cur) == side_eff - SIDE_W'(1)) &&
                            (SIDE_W'(col_cur) == side_eff - SIDE_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read at accept, write back in the cycle after, no later
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ctrl.mem_we) begin
            older_mem[cur_col_reg[ADDR_W-1:0]] <= newer_rd_reg;
            newer_mem[cur_col_reg[ADDR_W-1:0]] <= pix_reg;
        end
        if (ctrl.accept) begin
            older_rd_reg <= older_mem[col_cur[ADDR_W-1:0]];
            newer_rd_reg <= newer_mem[col_cur[ADDR_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Gradients from window and right column
    // ------------------------------------------------------------------
    logic signed [GRAD_W-1:0] l0, l1, l2, m0, m2, r0, r1, r2;
    logic signed [GRAD_W-1:0] gx_calc, gy_calc;

    always_comb begin
        l0 = GRAD_W'($signed(win_reg[0]));
        l1 = GRAD_W'($signed(win_reg[1]));
        l2 = GRAD_W'($signed(win_reg[2]));
        m0 = GRAD_W'($signed(win_reg[3]));
        m2 = GRAD_W'($signed(win_reg[5]));
        r0 = GRAD_W'($signed(older_rd_reg));
        r1 = GRAD_W'($signed(newer_rd_reg));
        r2 = GRAD_W'($signed(pix_reg));
        gx_calc = (l0 + (l1 <<< 1) + l2) - (r0 + (r1 <<< 1) + r2);
        gy_calc = (l0 + (m0 <<< 1) + r0) - (l2 + (m2 <<< 1) + r2);
    end

    // Shift the window and hold the gradients
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WIN_N; i++) begin
                win_reg[i] <= '0;
            end
        end else if (ctrl.mem_we) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= older_rd_reg;
            win_reg[4] <= newer_rd_reg;
            win_reg[5] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mem_we) begin
            gx_reg <= gx_calc;
            gy_reg <= gy_calc;
        end
    end

    // ------------------------------------------------------------------
    // Squares, then their sum into the root unit
    // ------------------------------------------------------------------
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.do_square) begin
            sqx_reg <= gx_sq[SQ_W-1:0];
            sqy_reg <= gy_sq[SQ_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Digit-by-digit square root, one result bit per cycle
    // ------------------------------------------------------------------
    logic [RAD_W:0] trial;
    always_comb begin
        trial     = root_reg + (RAD_W+1)'(bit_reg);
        rem_next  = rem_reg;
        root_next = root_reg >> 1;
        if ((RAD_W+1)'(rem_reg) >= trial) begin
            rem_next  = rem_reg - trial[RAD_W-1:0];
            root_next = (root_reg >> 1) + (RAD_W+1)'(bit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.do_sum) begin
            rem_reg  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            root_reg <= '0;
            bit_reg  <= RAD_W'(1) << (2 * (ROOT_STEPS - 1));
            step_reg <= '0;
        end else if (ctrl.do_root) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            mag_reg     <= root_reg[MAG_W-1:0];
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(16 - MAG_W)'(0), mag_reg};
    assign m_tlast  = m_tlast_reg;

endmodule
